// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the bitmap block, included by the engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/bfsc_pkg.sv =====
// Package of the bitmap block: field widths, opcodes and the bit-position encoder.
`default_nettype none

package bfsc_pkg;

  // Field widths
  localparam int OPC_W  = 3;
  localparam int IDX_W  = 12;
  localparam int FI_W   = 13;
  localparam int WORD_W = 64;
  localparam int OFS_W  = 6;
  localparam int WN_W   = FI_W - OFS_W;

  // Default bitmap size and reset value of the bits-in-use register
  localparam int BITS_DEFAULT = 4096;
  localparam logic [FI_W-1:0] LIMIT_RESET = 13'd4096;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_SET  = 3'd0;
  localparam logic [OPC_W-1:0] OP_CLR  = 3'd1;
  localparam logic [OPC_W-1:0] OP_TEST = 3'd2;
  localparam logic [OPC_W-1:0] OP_FZ   = 3'd3;
  localparam logic [OPC_W-1:0] OP_FS   = 3'd4;

  // Position of the lowest set bit of a word (0 when the word is zero)
  function automatic logic [OFS_W-1:0] lowest_set(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] oh;
    logic [OFS_W-1:0]  p;
    oh = x & (~x + 64'd1);
    p  = '0;
    for (int i = 0; i < WORD_W; i++) begin
      p = p | (oh[i] ? OFS_W'(i) : '0);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfsc_ifs.sv =====
// Request and response channel interfaces of the bitmap block.
`default_nettype none

interface bfsc_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfsc_pkg::OPC_W-1:0]  opcode;
  logic [bfsc_pkg::IDX_W-1:0]  bit_index;

  modport source (output valid, output opcode, output bit_index, input ready);
  modport sink   (input valid, input opcode, input bit_index, output ready);
endinterface

interface bfsc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        old_bit;
  logic [bfsc_pkg::FI_W-1:0]   found_index;
  logic                        found;

  modport source (output valid, output old_bit, output found_index, output found,
                  input ready);
  modport sink   (input valid, input old_bit, input found_index, input found,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bitmap_find_set_clear.sv =====
// Top level of the allocation bitmap with set, clear, test and upward search.
//
//   channel   direction  handshake          payload
//   in_req    sink       valid/ready        opcode, bit_index
//   out_rsp   source     valid/ready        old_bit, found_index, found
//   cfg       sink       cfg_we (no wait)   cfg_data = bits_in_use
//
// Set, clear and test read the word; set and clear then update the bit and write the word back.
// A search reads 64-bit words one per cycle through the single memory read port from the
// start word onward, up to the last word in use, and stops at the first word with a candidate.
// After reset a clearing sweep writes one word per cycle over all WORD_COUNT words (64 by default),
// during which no request is accepted.
// A result waits in the output register; the next request is accepted meanwhile and
// its result is held until the output register frees up.
`default_nettype none

module bitmap_find_set_clear #(
  parameter int BITMAP_BITS = bfsc_pkg::BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bfsc_req_if.sink                         in_req,
  bfsc_rsp_if.source                       out_rsp,
  input  wire logic                        cfg_we,
  input  wire logic [bfsc_pkg::FI_W-1:0]   cfg_data
);

  localparam int WORD_COUNT = (BITMAP_BITS + bfsc_pkg::WORD_W - 1) / bfsc_pkg::WORD_W;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [bfsc_pkg::FI_W-1:0]   bits_in_use_r;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [bfsc_pkg::WORD_W-1:0] mem_wd;
  logic                        mem_re;
  logic [AW-1:0]               mem_ra;
  logic [bfsc_pkg::WORD_W-1:0] mem_rd;

  // Bits-in-use register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= bfsc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      bits_in_use_r <= cfg_data;
    end
  end

  bfsc_engine #(
    .BITMAP_BITS (BITMAP_BITS),
    .WORD_COUNT  (WORD_COUNT),
    .AW          (AW)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .bits_in_use (bits_in_use_r),
    .mem_we      (mem_we),
    .mem_wa      (mem_wa),
    .mem_wd      (mem_wd),
    .mem_re      (mem_re),
    .mem_ra      (mem_ra),
    .mem_rd      (mem_rd)
  );

  bfsc_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bfsc_ram.sv =====
// Bitmap word memory: one write port, one read port with registered data.
`default_nettype none

module bfsc_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 wa,
  input  wire logic [bfsc_pkg::WORD_W-1:0]   wd,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 ra,
  output logic      [bfsc_pkg::WORD_W-1:0]   rd
);

  logic [bfsc_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bfsc_pkg::WORD_W-1:0] rd_r;

  // Write the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bfsc_engine.sv =====
// Request sequencer: clearing sweep, read-modify-write of one bit, word-wise search.
`default_nettype none
`include "assert_macros.svh"

module bfsc_engine #(
  parameter int BITMAP_BITS = bfsc_pkg::BITS_DEFAULT,
  parameter int WORD_COUNT  = (BITMAP_BITS + bfsc_pkg::WORD_W - 1) / bfsc_pkg::WORD_W,
  parameter int AW          = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bfsc_req_if.sink                           in_req,
  bfsc_rsp_if.source                         out_rsp,
  input  wire logic [bfsc_pkg::FI_W-1:0]     bits_in_use,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_wa,
  output logic      [bfsc_pkg::WORD_W-1:0]   mem_wd,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_ra,
  input  wire logic [bfsc_pkg::WORD_W-1:0]   mem_rd
);

  localparam int FI_W   = bfsc_pkg::FI_W;
  localparam int OFS_W  = bfsc_pkg::OFS_W;
  localparam int WN_W   = bfsc_pkg::WN_W;
  localparam int WORD_W = bfsc_pkg::WORD_W;
  localparam int IDX_W  = bfsc_pkg::IDX_W;

  localparam logic [AW-1:0] CLR_LAST = AW'(WORD_COUNT - 1);

  // State codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                clr_cnt_r;
  logic [bfsc_pkg::OPC_W-1:0]   op_r;
  logic [OFS_W-1:0]             off_r;
  logic [FI_W-1:0]              limit_r;
  logic [WN_W-1:0]              last_w_r;
  logic [WN_W-1:0]              scan_w_r;
  logic                         first_r;
  logic                         want_r;

  logic                         out_valid_r;
  logic                         out_old_r;
  logic [FI_W-1:0]              out_idx_r;
  logic                         out_found_r;
  logic                         hold_old_r;
  logic [FI_W-1:0]              hold_idx_r;
  logic                         hold_found_r;

  logic                         in_acc;
  logic                         out_free;
  logic [FI_W-1:0]              limit;
  logic [FI_W-1:0]              limit_m1;
  logic                         idx_ok;
  logic                         start_ok;
  logic                         cap_en;
  logic                         scan_adv;
  logic                         done;
  logic                         d_old;
  logic [FI_W-1:0]              d_idx;
  logic                         d_found;
  logic [WORD_W-1:0]            bit_mask;
  logic [WORD_W-1:0]            cand;
  logic                         hit;
  logic [FI_W-1:0]              pos;

  // Handshake
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Saturate the search limit to the bitmap size
  assign limit    = (32'(bits_in_use) < BITMAP_BITS) ? bits_in_use : FI_W'(BITMAP_BITS);
  assign limit_m1 = limit - FI_W'(1);
  assign idx_ok   = 32'(in_req.bit_index) < BITMAP_BITS;
  assign start_ok = {1'b0, in_req.bit_index} < limit;

  // Search candidates in the word just read
  assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << off_r;
  assign cand     = (want_r ? mem_rd : ~mem_rd) & (first_r ? ({WORD_W{1'b1}} << off_r)
                                                           : {WORD_W{1'b1}});
  assign hit      = |cand;
  assign pos      = {scan_w_r, bfsc_pkg::lowest_set(cand)};

  // Sequence the current request
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    cap_en    = 1'b0;
    scan_adv  = 1'b0;
    done      = 1'b0;
    d_old     = 1'b0;
    d_idx     = '0;
    d_found   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cap_en = 1'b1;
          unique case (in_req.opcode) inside
            bfsc_pkg::OP_SET, bfsc_pkg::OP_CLR, bfsc_pkg::OP_TEST: begin
              if (idx_ok) begin
                mem_re    = 1'b1;
                mem_ra    = AW'(in_req.bit_index[IDX_W-1:OFS_W]);
                state_nxt = ST_RMW;
              end else begin
                done = 1'b1;
              end
            end
            bfsc_pkg::OP_FZ, bfsc_pkg::OP_FS: begin
              if (start_ok) begin
                mem_re    = 1'b1;
                mem_ra    = AW'(in_req.bit_index[IDX_W-1:OFS_W]);
                state_nxt = ST_SCAN;
              end else begin
                done  = 1'b1;
                d_idx = limit;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_RMW: begin
        done   = 1'b1;
        d_old  = mem_rd[off_r];
        mem_wa = AW'(scan_w_r);
        if (op_r == bfsc_pkg::OP_SET) begin
          mem_we = 1'b1;
          mem_wd = mem_rd | bit_mask;
        end else if (op_r == bfsc_pkg::OP_CLR) begin
          mem_we = 1'b1;
          mem_wd = mem_rd & ~bit_mask;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          done    = 1'b1;
          d_found = pos < limit_r;
          d_idx   = d_found ? pos : limit_r;
        end else if (scan_w_r == last_w_r) begin
          done  = 1'b1;
          d_idx = limit_r;
        end else begin
          scan_adv = 1'b1;
          mem_re   = 1'b1;
          mem_ra   = AW'(scan_w_r + WN_W'(1));
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (done) begin
      state_nxt = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Capture the request and step the scan word
  always_ff @(posedge clk) begin
    if (cap_en) begin
      op_r     <= in_req.opcode;
      off_r    <= in_req.bit_index[OFS_W-1:0];
      limit_r  <= limit;
      last_w_r <= limit_m1[FI_W-1:OFS_W];
      scan_w_r <= WN_W'(in_req.bit_index[IDX_W-1:OFS_W]);
      first_r  <= 1'b1;
      want_r   <= (in_req.opcode == bfsc_pkg::OP_FS);
    end else if (scan_adv) begin
      scan_w_r <= scan_w_r + WN_W'(1);
      first_r  <= 1'b0;
    end
  end

  // Hold a finished result while the output register is occupied
  always_ff @(posedge clk) begin
    if (done && !out_free) begin
      hold_old_r   <= d_old;
      hold_idx_r   <= d_idx;
      hold_found_r <= d_found;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HOLD && out_free) begin
      out_old_r   <= hold_old_r;
      out_idx_r   <= hold_idx_r;
      out_found_r <= hold_found_r;
    end else if (done && out_free) begin
      out_old_r   <= d_old;
      out_idx_r   <= d_idx;
      out_found_r <= d_found;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.old_bit     = out_old_r;
  assign out_rsp.found_index = out_idx_r;
  assign out_rsp.found       = out_found_r;

  // Checks
  `ASSERT_IMPL(a_found_below_limit, clk, rst_n,
               out_valid_r && out_found_r |-> (out_idx_r < limit_r),
               "found index at or past the search limit")
  `ASSERT_NEVER(a_scan_in_range, clk, rst_n,
                (state_r == ST_SCAN) && (scan_w_r > last_w_r),
                "scan ran past the last word")
  `ASSERT_IMPL(a_request_progress, clk, rst_n,
               in_acc |=> (state_r != ST_IDLE) || out_valid_r,
               "accepted request left no result")

endmodule

`default_nettype wire
